[sv/abump_pkg.sv]
package abump_pkg;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned SIZE_W      = 32;
	localparam int unsigned ALIGN_W     = 4;
	localparam int unsigned STATUS_W    = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_ALIGN_LOG2 = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_SIZE   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_INIT_CAP   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

	localparam logic KIND_ALLOC  = 1'b0;
	localparam logic KIND_REWIND = 1'b1;

	localparam logic [ALIGN_W-1:0] RESET_ALIGN_LOG2 = 4'd8;
	localparam logic [SIZE_W-1:0]  RESET_ARENA_SIZE = 32'd65536;

	// Flags from the shared arithmetic unit.
	typedef struct packed {
		logic ge;    // a >= b
		logic wide;  // a + b does not fit the address width
	} abump_flags_t;

endpackage

[sv/abump_if.sv]
interface abump_req_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [31:0] request_size;

	modport source (output valid, output kind, output request_size, input ready);
	modport sink (input valid, input kind, input request_size, output ready);
endinterface

interface abump_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] alloc_offset;
	logic [31:0] capacity_now;

	modport source (output valid, output status, output alloc_offset, output capacity_now,
		input ready);
	modport sink (input valid, input status, input alloc_offset, input capacity_now,
		output ready);
endinterface

[sv/aligned_bump_allocator.sv]
// A rewind word goes straight to the done step; an allocation runs the size, align, end and
// fit steps, then doubles a short capacity on the shared add/compare unit until it covers
// the end. The result is registered in the done step once the output register is free.
// One word at a time: a new word is accepted while the previous result still waits on the output register.
// Reset (arst_n low, asynchronous): state, config and output registers return to their
// defaults, the cursor is zero and the capacity is the default initial capacity.
module aligned_bump_allocator #(
	parameter int unsigned ADDR_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [abump_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [abump_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	abump_req_if.sink                            req,
	abump_rsp_if.source                          rsp
);

	localparam int unsigned EXT_WIDTH =
		((ADDR_WIDTH > abump_pkg::SIZE_W) ? ADDR_WIDTH : abump_pkg::SIZE_W) + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SIZE,
		S_ALIGN,
		S_END,
		S_FIT,
		S_GROW,
		S_DONE
	} state_t;

	state_t                              state_q;
	logic [abump_pkg::ALIGN_W-1:0]       align_log2_q;
	logic [abump_pkg::SIZE_W-1:0]        max_size_q;
	logic [ADDR_WIDTH-1:0]               cursor_q;
	logic [ADDR_WIDTH-1:0]               cap_q;
	logic [abump_pkg::SIZE_W-1:0]        size_q;
	logic [ADDR_WIDTH-1:0]               off_q;
	logic [ADDR_WIDTH-1:0]               end_q;
	logic [ADDR_WIDTH-1:0]               grown_q;
	logic [abump_pkg::STATUS_W-1:0]      status_q;
	logic                                commit_q;
	logic                                rsp_valid_q;
	logic [abump_pkg::STATUS_W-1:0]      rsp_status_q;
	logic [31:0]                         rsp_offset_q;
	logic [31:0]                         rsp_cap_q;

	logic [ADDR_WIDTH-1:0]               align;
	logic [ADDR_WIDTH-1:0]               low;
	logic [EXT_WIDTH-1:0]                alu_a;
	logic [EXT_WIDTH-1:0]                alu_b;
	logic [EXT_WIDTH-1:0]                alu_sum;
	abump_pkg::abump_flags_t             alu_flags;
	logic                                accept;
	logic                                out_free;

	assign align    = ADDR_WIDTH'(1) << align_log2_q;
	assign low      = align - ADDR_WIDTH'(1);
	assign accept   = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;

	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.alloc_offset = rsp_offset_q;
	assign rsp.capacity_now = rsp_cap_q;

	// Operand selection for the shared unit, one use per sequencer step.
	always_comb begin
		case (state_q)
			S_SIZE: begin
				alu_a = EXT_WIDTH'(max_size_q);
				alu_b = EXT_WIDTH'(size_q);
			end
			S_ALIGN: begin
				alu_a = EXT_WIDTH'(cursor_q);
				alu_b = EXT_WIDTH'(low);
			end
			S_END: begin
				alu_a = EXT_WIDTH'(off_q);
				alu_b = EXT_WIDTH'(size_q);
			end
			S_FIT: begin
				alu_a = EXT_WIDTH'(cap_q);
				alu_b = EXT_WIDTH'(end_q);
			end
			S_GROW: begin
				alu_a = EXT_WIDTH'(grown_q);
				alu_b = EXT_WIDTH'(end_q);
			end
			default: begin
				alu_a = '0;
				alu_b = '0;
			end
		endcase
	end

	abump_alu #(
		.ADDR_WIDTH(ADDR_WIDTH),
		.EXT_WIDTH (EXT_WIDTH)
	) u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.sum  (alu_sum),
		.flags(alu_flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			align_log2_q <= abump_pkg::RESET_ALIGN_LOG2;
			max_size_q   <= abump_pkg::RESET_ARENA_SIZE;
			cursor_q     <= '0;
			cap_q        <= ADDR_WIDTH'(abump_pkg::RESET_ARENA_SIZE);
			status_q     <= abump_pkg::ST_OK;
			commit_q     <= 1'b0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= abump_pkg::ST_OK;
			rsp_offset_q <= '0;
			rsp_cap_q    <= '0;
		end else begin
			// In the done step a free output register is refilled below instead.
			if (rsp_valid_q && rsp.ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.kind == abump_pkg::KIND_REWIND) begin
							cursor_q <= '0;
							status_q <= abump_pkg::ST_OK;
							commit_q <= 1'b0;
							state_q  <= S_DONE;
						end else begin
							size_q  <= req.request_size;
							state_q <= S_SIZE;
						end
					end
				end
				S_SIZE: begin
					if (size_q == '0 || !alu_flags.ge) begin
						status_q <= abump_pkg::ST_BAD_SIZE;
						commit_q <= 1'b0;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_ALIGN;
					end
				end
				S_ALIGN: begin
					if (alu_flags.wide) begin
						status_q <= abump_pkg::ST_OVERFLOW;
						commit_q <= 1'b0;
						state_q  <= S_DONE;
					end else begin
						off_q   <= ADDR_WIDTH'(alu_sum) & ~low;
						state_q <= S_END;
					end
				end
				S_END: begin
					if (alu_flags.wide) begin
						status_q <= abump_pkg::ST_OVERFLOW;
						commit_q <= 1'b0;
						state_q  <= S_DONE;
					end else begin
						end_q   <= ADDR_WIDTH'(alu_sum);
						state_q <= S_FIT;
					end
				end
				S_FIT: begin
					status_q <= abump_pkg::ST_OK;
					commit_q <= 1'b1;
					if (alu_flags.ge) begin
						grown_q <= cap_q;
						state_q <= S_DONE;
					end else begin
						grown_q <= (cap_q == '0) ? align : cap_q;
						state_q <= S_GROW;
					end
				end
				S_GROW: begin
					if (alu_flags.ge) begin
						state_q <= S_DONE;
					end else if (grown_q[ADDR_WIDTH-1]) begin
						// Doubling would leave the address range: take the end exactly.
						grown_q <= end_q;
						state_q <= S_DONE;
					end else begin
						grown_q <= grown_q << 1;
					end
				end
				S_DONE: begin
					if (out_free) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= status_q;
						rsp_offset_q <= commit_q ? 32'(off_q) : '0;
						rsp_cap_q    <= commit_q ? 32'(grown_q) : 32'(cap_q);
						if (commit_q) begin
							cursor_q <= end_q;
							cap_q    <= grown_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (cfg_we) begin
				case (cfg_index)
					abump_pkg::REG_ALIGN_LOG2: begin
						align_log2_q <= cfg_wdata[abump_pkg::ALIGN_W-1:0];
					end
					abump_pkg::REG_MAX_SIZE: begin
						max_size_q <= cfg_wdata;
					end
					abump_pkg::REG_INIT_CAP: begin
						cap_q    <= ADDR_WIDTH'(cfg_wdata);
						cursor_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

`ifndef SYNTHESIS
	// The grown capacity never shrinks while the doubling loop runs.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GROW) |=> (grown_q >= $past(grown_q)))
		else $error("capacity shrank during growth");

	// A committed allocation always leaves a capacity that covers its end.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && commit_q) |-> (grown_q >= end_q && end_q > off_q))
		else $error("committed capacity does not cover the allocation");

	// Offsets handed out are aligned to the current alignment.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && commit_q) |-> ((off_q & low) == '0))
		else $error("allocation offset is not aligned");
`endif

endmodule

[sv/abump_alu.sv]
module abump_alu #(
	parameter int unsigned ADDR_WIDTH = 32,
	parameter int unsigned EXT_WIDTH  = 33
) (
	input  logic [EXT_WIDTH-1:0] a,
	input  logic [EXT_WIDTH-1:0] b,
	output logic [EXT_WIDTH-1:0] sum,
	output abump_pkg::abump_flags_t flags
);

	always_comb begin
		sum        = a + b;
		flags.ge   = (a >= b);
		// Any bit above the address width means the sum left the address range.
		flags.wide = |sum[EXT_WIDTH-1:ADDR_WIDTH];
	end

endmodule
